/* hdl/wshm_pkg.sv */
// ----------------------------------------------------------------------------
// wshm_pkg
// Shared types and constants for the wind stow hysteresis monitor.
// ----------------------------------------------------------------------------
package wshm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_W    = 15;
  localparam int RAW_W       = 16;
  localparam int THR_W       = 15;
  localparam int DELAY_W     = 16;
  localparam int WLEN_W      = 7;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_AW      = 3;
  localparam int BLOCK_LIMIT = 32760;

  localparam int AW      = $clog2(WINDOW_MAX);
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W   = $clog2(WINDOW_MAX * BLOCK_LIMIT + 1);
  localparam int LIM_W   = THR_W + CNT_W;
  localparam int DCNT_W  = $clog2(SUM_W);

  typedef enum logic [CFG_AW-1:0] {
    CFG_STOW_THR   = 3'd0,
    CFG_UNSTOW_THR = 3'd1,
    CFG_STOW_DLY   = 3'd2,
    CFG_UNSTOW_DLY = 3'd3,
    CFG_WIN_LEN    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DECIDE
  } ctrl_state_e;

  typedef struct packed {
    logic               read_ok;
    logic [RAW_W-1:0]   raw_reading;
    logic [THR_W-1:0]   forecast_speed;
  } in_item_t;

  typedef struct packed {
    logic                stow_command;
    logic [SAMPLE_W-1:0] current_speed;
    logic [SAMPLE_W-1:0] average_speed;
    logic                comm_fault;
    logic                blocked_fault;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic sum_step;
    logic div_load;
    logic div_step;
    logic decide;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sum_last;
    logic div_last;
  } dp_sts_t;

endpackage

/* hdl/wshm_ctrl.sv */
// ----------------------------------------------------------------------------
// wshm_ctrl
// Sequencer: accept, window sum, serial divide, stow decision, result slot.
// ----------------------------------------------------------------------------
module wshm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  wshm_pkg::dp_sts_t  sts_i,
  output wshm_pkg::ctrl_cmd_t cmd_o
);

  wshm_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wshm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wshm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = wshm_pkg::ST_SUM;
      end
      wshm_pkg::ST_SUM: begin
        if (sts_i.sum_last) state_d = wshm_pkg::ST_DIV_LOAD;
      end
      wshm_pkg::ST_DIV_LOAD: begin
        state_d = wshm_pkg::ST_DIV;
      end
      wshm_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = wshm_pkg::ST_DECIDE;
      end
      wshm_pkg::ST_DECIDE: begin
        if (out_free) state_d = wshm_pkg::ST_IDLE;
      end
      default: state_d = wshm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wshm_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      wshm_pkg::ST_SUM:      cmd_o.sum_step = 1'b1;
      wshm_pkg::ST_DIV_LOAD: cmd_o.div_load = 1'b1;
      wshm_pkg::ST_DIV:      cmd_o.div_step = 1'b1;
      wshm_pkg::ST_DECIDE:   cmd_o.decide   = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.decide;
  assign out_valid_o = out_valid_q;

endmodule

/* hdl/wshm_dp.sv */
// ----------------------------------------------------------------------------
// wshm_dp
// Datapath: config registers, sample window RAM, sum, divider, stow state.
// ----------------------------------------------------------------------------
module wshm_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wshm_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [wshm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wshm_pkg::in_item_t             in_data_i,
  input  wshm_pkg::ctrl_cmd_t            cmd_i,
  output wshm_pkg::dp_sts_t              sts_o,
  output wshm_pkg::out_item_t            out_data_o
);

  localparam int AW    = wshm_pkg::AW;
  localparam int CNT_W = wshm_pkg::CNT_W;
  localparam int SUM_W = wshm_pkg::SUM_W;
  localparam int LIM_W = wshm_pkg::LIM_W;
  localparam int SW    = wshm_pkg::SAMPLE_W;
  localparam int DW    = wshm_pkg::DELAY_W;
  localparam int PW    = CNT_W + 1;

  // configuration
  logic [wshm_pkg::THR_W-1:0]  stow_thr_q, unstow_thr_q;
  logic [DW-1:0]               stow_dly_q, unstow_dly_q;
  logic [wshm_pkg::WLEN_W-1:0] win_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stow_thr_q   <= wshm_pkg::THR_W'(200);
      unstow_thr_q <= wshm_pkg::THR_W'(150);
      stow_dly_q   <= DW'(3);
      unstow_dly_q <= DW'(600);
      win_len_q    <= wshm_pkg::WLEN_W'(8);
    end else if (cfg_we_i) begin
      unique case (wshm_pkg::cfg_idx_e'(cfg_addr_i))
        wshm_pkg::CFG_STOW_THR:   stow_thr_q   <= cfg_wdata_i[wshm_pkg::THR_W-1:0];
        wshm_pkg::CFG_UNSTOW_THR: unstow_thr_q <= cfg_wdata_i[wshm_pkg::THR_W-1:0];
        wshm_pkg::CFG_STOW_DLY:   stow_dly_q   <= cfg_wdata_i[DW-1:0];
        wshm_pkg::CFG_UNSTOW_DLY: unstow_dly_q <= cfg_wdata_i[DW-1:0];
        wshm_pkg::CFG_WIN_LEN:    win_len_q    <= cfg_wdata_i[wshm_pkg::WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window length
  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (win_len_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(win_len_q) > wshm_pkg::WINDOW_MAX) begin
      n_eff = CNT_W'(wshm_pkg::WINDOW_MAX);
    end else begin
      n_eff = CNT_W'(win_len_q);
    end
  end

  // sample conditioning
  logic          blk_in, clr_in;
  logic [SW-1:0] smp_in;
  assign blk_in = in_data_i.read_ok &&
                  (32'(in_data_i.raw_reading) > wshm_pkg::BLOCK_LIMIT);
  assign clr_in = in_data_i.read_ok &&
                  (32'(in_data_i.raw_reading) < wshm_pkg::BLOCK_LIMIT);
  assign smp_in = (in_data_i.read_ok && !blk_in) ? in_data_i.raw_reading[SW-1:0] : '0;

  logic [SW-1:0]             smp_q;
  logic                      blk_q;
  logic [wshm_pkg::THR_W-1:0] fc_q;
  logic [LIM_W-1:0]          hi_lim_q, lo_lim_q;
  logic                      comm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q    <= smp_in;
      blk_q    <= blk_in;
      fc_q     <= in_data_i.forecast_speed;
      hi_lim_q <= LIM_W'(stow_thr_q) * LIM_W'(n_eff);
      lo_lim_q <= LIM_W'(unstow_thr_q) * LIM_W'(n_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comm_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (!in_data_i.read_ok) comm_q <= 1'b1;
      else if (clr_in)        comm_q <= 1'b0;
    end
  end

  // window RAM, circular; newest entry at wptr_q
  logic [SW-1:0]    mem_q [wshm_pkg::WINDOW_MAX];
  logic [AW-1:0]    wptr_q, wptr_nx;
  logic [CNT_W-1:0] fill_q;

  assign wptr_nx = (32'(wptr_q) == wshm_pkg::WINDOW_MAX - 1) ? '0 : wptr_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.accept) begin
      wptr_q <= wptr_nx;
      if (32'(fill_q) < wshm_pkg::WINDOW_MAX) fill_q <= fill_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) mem_q[wptr_nx] <= smp_in;
  end

  // summation over the newest n_eff entries
  logic [CNT_W-1:0] idx_q;
  logic [SUM_W-1:0] sum_q;
  logic [PW-1:0]    rd_full;
  logic [AW-1:0]    rd_addr;
  logic [SW-1:0]    rd_data_q;
  logic             rd_vld_q;

  always_comb begin
    if (PW'(wptr_q) >= PW'(idx_q)) begin
      rd_full = PW'(wptr_q) - PW'(idx_q);
    end else begin
      rd_full = PW'(wptr_q) + PW'(wshm_pkg::WINDOW_MAX) - PW'(idx_q);
    end
  end
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
    rd_vld_q  <= idx_q < fill_q;
  end

  assign sts_o.sum_last = cmd_i.sum_step && (idx_q == n_eff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.sum_step) begin
      idx_q <= idx_q + CNT_W'(1);
      if (idx_q != '0 && rd_vld_q) sum_q <= sum_q + SUM_W'(rd_data_q);
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [SUM_W-1:0]          quo_q;
  logic [CNT_W-1:0]          rem_q;
  logic [wshm_pkg::DCNT_W-1:0] dcnt_q;
  logic [CNT_W:0]            rem_sh, rem_df;
  logic                      q_bit;

  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign q_bit  = rem_sh >= {1'b0, n_eff};
  assign rem_df = q_bit ? (rem_sh - {1'b0, n_eff}) : rem_sh;
  assign sts_o.div_last = cmd_i.div_step &&
                          (32'(dcnt_q) == SUM_W - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quo_q  <= sum_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[SUM_W-2:0], q_bit};
      rem_q  <= rem_df[CNT_W-1:0];
      dcnt_q <= dcnt_q + wshm_pkg::DCNT_W'(1);
    end
  end

  // stow hysteresis
  logic          stow_q, stow_d;
  logic [DW-1:0] scnt_q, scnt_d, ucnt_q, ucnt_d, sinc, uinc;
  logic          high_avg, low_avg, high_fc, low_fc;

  assign high_avg = LIM_W'(sum_q) >= hi_lim_q;
  assign low_avg  = LIM_W'(sum_q) <  lo_lim_q;
  assign high_fc  = fc_q >= stow_thr_q;
  assign low_fc   = fc_q <  unstow_thr_q;
  assign sinc     = (scnt_q == '1) ? scnt_q : scnt_q + DW'(1);
  assign uinc     = (ucnt_q == '1) ? ucnt_q : ucnt_q + DW'(1);

  always_comb begin
    stow_d = stow_q;
    scnt_d = scnt_q;
    ucnt_d = ucnt_q;
    if (high_avg && !stow_q) begin
      scnt_d = sinc;
      if (sinc >= stow_dly_q) begin
        stow_d = 1'b1;
        scnt_d = '0;
      end
    end else if (high_fc && !stow_q) begin
      stow_d = 1'b1;
    end else if (low_avg && low_fc && stow_q) begin
      ucnt_d = uinc;
      if (uinc >= unstow_dly_q) begin
        stow_d = 1'b0;
        ucnt_d = '0;
      end
    end else if (high_avg || (low_avg && (scnt_q != '0 || ucnt_q != '0))) begin
      scnt_d = '0;
      ucnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stow_q <= 1'b0;
      scnt_q <= '0;
      ucnt_q <= '0;
    end else if (cmd_i.decide) begin
      stow_q <= stow_d;
      scnt_q <= scnt_d;
      ucnt_q <= ucnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      out_data_o.stow_command  <= stow_d;
      out_data_o.current_speed <= smp_q;
      out_data_o.average_speed <= quo_q[SW-1:0];
      out_data_o.comm_fault    <= comm_q;
      out_data_o.blocked_fault <= blk_q;
    end
  end

endmodule

/* hdl/wind_stow_hysteresis_monitor_top.sv */
// ----------------------------------------------------------------------------
// wind_stow_hysteresis_monitor_top
// Wind stow monitor: moving average of anemometer reads with stow hysteresis.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one request per read:
// read_ok, raw_reading and forecast_speed. Output channel (out_valid_o/
// out_ready_i/out_data_o) returns one result per request.
// Configuration is a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i);
// write it only while no request is in flight; the block does not enforce it.
// The window sum reads the sample RAM one entry a cycle over the effective
// window length n (1..64), then a restoring divider forms the average. A
// new request is taken only once the previous one has been decided.
// A finished result sits in an output register, so the next request is
// taken while it waits; if the receiver still stalls when the following
// result is ready, the block holds it and takes no new request.
// Reset (rst_ni low, asynchronous) restores register defaults, clears stow
// state, counters, fault flag and the window fill count; no clearing pass.
// ----------------------------------------------------------------------------
module wind_stow_hysteresis_monitor_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  wshm_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wshm_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [wshm_pkg::CFG_AW-1:0]     cfg_addr_i,
  input  logic [wshm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  wshm_pkg::ctrl_cmd_t cmd;
  wshm_pkg::dp_sts_t   sts;

  wshm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wshm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
